// File: hdl/gmsm_pkg.sv
// Shared constants, types and helper functions of the gradient max smear map core.
// No dependencies; every other file of the block but gmsm_ram refers to it by scoped names.
`default_nettype none

package gmsm_pkg;

	// Build limits
	localparam int MAX_WIDTH     = 1024;
	localparam int MAX_HEIGHT    = 1024;
	localparam int MAG_FRAC_BITS = 4;

	// Field widths
	localparam int CFG_W  = 11;
	localparam int THR_W  = 12;
	localparam int PIX_W  = 8;
	localparam int GRAD_W = 9;
	localparam int MAG_W  = 12;
	localparam int POS_W  = 20;
	localparam int CNT_W  = 21;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [MAG_W-1:0] MAG_MAX = '1;

	// Dimension clamps
	localparam int MIN_WIDTH  = 8;
	localparam int MIN_HEIGHT = 4;

	// Line store address widths: pixel and magnitude lines hold more than two rows,
	// the gradient delay line more than one row plus one.
	localparam int PIX_AW  = $clog2(2 * MAX_WIDTH + 1);
	localparam int GDEL_AW = $clog2(MAX_WIDTH + 2);
	localparam int GDEL_W  = 2 * GRAD_W + PIX_W;

	// Wide position arithmetic for the range compares
	localparam int KX_W = CNT_W + 3;

	// Square root datapath
	localparam int SQ_W   = 2 * (GRAD_W - 1) + 1;
	localparam int RAD_W  = ((SQ_W + 2 * MAG_FRAC_BITS + 1) / 2) * 2;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 3;

	// APB register map
	localparam int ADDR_W    = 4;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MIN_GRAD     = 2'd2;

	localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
	localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 11'd480;
	localparam logic [THR_W-1:0] RST_MIN_GRAD     = 12'd80;

	// Per-item control flags, decided once from the item index
	typedef struct packed {
		logic mag_we;   // a magnitude entry is written for this item
		logic grad_ok;  // gradient position inside the gradient rows
		logic vert_ok;  // vertical maximum position inside the interior
		logic res_ok;   // this item produces a result
		logic last;     // result is the final one of the frame
		logic fs;       // frame start: clears the mappable count
	} gmsm_flags_t;

	// Side data that travels alongside the square root pipeline
	typedef struct packed {
		gmsm_flags_t                flags;
		logic signed [GRAD_W-1:0]   gx;
		logic signed [GRAD_W-1:0]   gy;
		logic [PIX_W-1:0]           intensity;
		logic [PIX_AW-1:0]          mag_wa;    // q
		logic [PIX_AW-1:0]          mag_ra0;   // p
		logic [PIX_AW-1:0]          mag_ra1;   // p - width
		logic [GDEL_AW-1:0]         gdel_wa;   // q
		logic [GDEL_AW-1:0]         gdel_ra;   // result position
		logic [POS_W-1:0]           position;
	} gmsm_side_t;

	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] raw,
		input int lo, input int hi);
		logic [CFG_W-1:0] r;
		r = raw;
		if (int'(raw) < lo) begin
			r = CFG_W'(lo);
		end else if (int'(raw) > hi) begin
			r = CFG_W'(hi);
		end
		return r;
	endfunction

	function automatic logic [MAG_W-1:0] max3(input logic [MAG_W-1:0] a,
		input logic [MAG_W-1:0] b, input logic [MAG_W-1:0] c);
		logic [MAG_W-1:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

endpackage

`default_nettype wire

// File: hdl/gradient_max_smear_map_core.sv
// Top level of the gradient max smear map core: APB registers, stall control and
// the front end, square root and back end. Depends on gmsm_pkg, gmsm_front, gmsm_sqrt and gmsm_back.
//
// The core takes one pixel per clock and gives the interior positions of each frame
// with their central-difference gradients, intensity, 3x3 smeared gradient magnitude,
// mappable flag and running mappable count. Throughput is one item per cycle while the
// pipeline is not held, set by the single-port-per-copy line stores that are read and
// written once per item; the pipeline has 20 register stages from the accepting edge of
// the item that completes a result to the output, and that item comes 2*width+1 items
// after the result's own pixel, so a frame needs width pad items after its last pixel.
// The whole pipeline holds only while a result waits in the output register and
// another result is ready behind it. Every line store entry is written inside the
// frame before it is read, so there is no clearing pass after reset. image_width must
// not change in the middle of a frame.
`default_nettype none

module gradient_max_smear_map_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [gmsm_pkg::PIX_W-1:0]          pixel,
	input  wire logic                                frame_start,
	input  wire logic                                pad,
	// output channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [gmsm_pkg::POS_W-1:0]               position,
	output logic signed [gmsm_pkg::GRAD_W-1:0]       grad_x_half,
	output logic signed [gmsm_pkg::GRAD_W-1:0]       grad_y_half,
	output logic [gmsm_pkg::PIX_W-1:0]               intensity,
	output logic [gmsm_pkg::MAG_W-1:0]               max_grad,
	output logic                                     mappable,
	output logic [gmsm_pkg::CNT_W-1:0]               mappable_count,
	output logic                                     frame_last,
	// APB configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [gmsm_pkg::ADDR_W-1:0]         paddr,
	input  wire logic [31:0]                         pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready
);

	// Configuration registers
	logic [gmsm_pkg::CFG_W-1:0] width_q, height_q;
	logic [gmsm_pkg::THR_W-1:0] thr_q;
	logic [gmsm_pkg::REG_IDX_W-1:0] reg_idx;
	logic cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[gmsm_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gmsm_pkg::RST_IMAGE_WIDTH;
			height_q <= gmsm_pkg::RST_IMAGE_HEIGHT;
			thr_q    <= gmsm_pkg::RST_MIN_GRAD;
		end else if (cfg_wr) begin
			case (reg_idx)
				gmsm_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[gmsm_pkg::CFG_W-1:0];
				gmsm_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[gmsm_pkg::CFG_W-1:0];
				gmsm_pkg::REG_MIN_GRAD:     thr_q    <= pwdata[gmsm_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			gmsm_pkg::REG_IMAGE_WIDTH:  prdata = 32'(width_q);
			gmsm_pkg::REG_IMAGE_HEIGHT: prdata = 32'(height_q);
			gmsm_pkg::REG_MIN_GRAD:     prdata = 32'(thr_q);
			default:                    prdata = '0;
		endcase
	end

	// Dimensions in use
	logic [gmsm_pkg::CFG_W-1:0] width_c, height_c;
	assign width_c  = gmsm_pkg::clamp_dim(width_q, gmsm_pkg::MIN_WIDTH, gmsm_pkg::MAX_WIDTH);
	assign height_c = gmsm_pkg::clamp_dim(height_q, gmsm_pkg::MIN_HEIGHT,
		gmsm_pkg::MAX_HEIGHT);

	// Pipeline advance: hold only when a waiting result would be overwritten
	logic adv, accept, res_pending;
	assign adv      = !(out_valid && out_stall && res_pending);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	logic                        rad_valid, root_valid;
	logic [gmsm_pkg::RAD_W-1:0]  rad;
	logic [gmsm_pkg::ROOT_W-1:0] root;
	gmsm_pkg::gmsm_side_t        side_front, side_root;

	gmsm_front u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv), .accept(accept),
		.pixel(pixel), .frame_start(frame_start), .pad(pad),
		.width(width_c), .height(height_c),
		.rad_valid(rad_valid), .rad(rad), .side(side_front)
	);

	gmsm_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(rad_valid), .rad(rad), .side_in(side_front),
		.out_valid(root_valid), .root(root), .side_out(side_root)
	);

	gmsm_back u_back (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(root_valid), .root(root), .side(side_root),
		.threshold(thr_q), .out_stall(out_stall), .res_pending(res_pending),
		.out_valid(out_valid), .position(position),
		.grad_x_half(grad_x_half), .grad_y_half(grad_y_half),
		.intensity(intensity), .max_grad(max_grad), .mappable(mappable),
		.mappable_count(mappable_count), .frame_last(frame_last)
	);

endmodule

`default_nettype wire

// File: hdl/gmsm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module gmsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/gmsm_front.sv
// Front end: item index, pixel line store, central differences, squares and radicand.
// Depends on gmsm_pkg and gmsm_ram.
`default_nettype none

module gmsm_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           adv,
	input  wire logic                           accept,
	input  wire logic [gmsm_pkg::PIX_W-1:0]     pixel,
	input  wire logic                           frame_start,
	input  wire logic                           pad,
	input  wire logic [gmsm_pkg::CFG_W-1:0]     width,
	input  wire logic [gmsm_pkg::CFG_W-1:0]     height,
	output logic                                rad_valid,
	output logic [gmsm_pkg::RAD_W-1:0]          rad,
	output gmsm_pkg::gmsm_side_t                side
);

	localparam int AW = gmsm_pkg::PIX_AW;

	// Item index and stage 0
	logic [gmsm_pkg::CNT_W-1:0]   k_q;
	logic [gmsm_pkg::CNT_W-1:0]   k_eff;
	logic [gmsm_pkg::PIX_W-1:0]   pix_eff;
	logic [AW-1:0]                wr_addr, rd_addr_near, rd_addr_far;
	logic [2*gmsm_pkg::CFG_W-1:0] wh1_prod;

	assign k_eff   = frame_start ? '0 : k_q;
	assign pix_eff = pad ? '0 : pixel;
	assign wr_addr = AW'(k_eff);
	// k - w + 1 and k - 2w
	assign rd_addr_near = AW'(k_eff) - AW'(width) + AW'(1);
	assign rd_addr_far  = AW'(k_eff) - AW'({width, 1'b0});
	assign wh1_prod = width * (height - gmsm_pkg::CFG_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (accept) begin
			k_q <= (k_eff == gmsm_pkg::CNT_MAX) ? gmsm_pkg::CNT_MAX : k_eff + 1'b1;
		end
	end

	// Pixel lines, two read ports as two copies sharing the write
	logic [gmsm_pkg::PIX_W-1:0] near_data, far_data;

	gmsm_ram #(.WIDTH(gmsm_pkg::PIX_W), .DEPTH(1 << AW)) u_pix_near (
		.clk(clk), .we(accept), .waddr(wr_addr), .wdata(pix_eff),
		.re(adv), .raddr(rd_addr_near), .rdata(near_data)
	);

	gmsm_ram #(.WIDTH(gmsm_pkg::PIX_W), .DEPTH(1 << AW)) u_pix_far (
		.clk(clk), .we(accept), .waddr(wr_addr), .wdata(pix_eff),
		.re(adv), .raddr(rd_addr_far), .rdata(far_data)
	);

	// Stage 1 registers
	logic                           v_s1, fs_s1;
	logic [gmsm_pkg::CNT_W-1:0]     k_s1;
	logic [gmsm_pkg::CFG_W-1:0]     w_s1;
	logic [gmsm_pkg::KX_W-1:0]      wh1_s1;
	logic [gmsm_pkg::PIX_W-1:0]     pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s1   <= k_eff;
			w_s1   <= width;
			wh1_s1 <= gmsm_pkg::KX_W'(wh1_prod);
			pix_s1 <= pix_eff;
			fs_s1  <= frame_start;
		end
	end

	// Taps on the near read: one item back is q, two back is q - 1
	logic [gmsm_pkg::PIX_W-1:0] tap1_q, tap2_q;

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			tap1_q <= near_data;
			tap2_q <= tap1_q;
		end
	end

	// Stage 1: differences, range flags and line addresses
	gmsm_pkg::gmsm_side_t side_c;
	logic [gmsm_pkg::KX_W-1:0] kx, wx, w2x, w3x;

	always_comb begin
		kx  = gmsm_pkg::KX_W'(k_s1);
		wx  = gmsm_pkg::KX_W'(w_s1);
		w2x = wx + wx;
		w3x = w2x + wx;

		side_c.flags.mag_we  = kx >= wx;
		side_c.flags.grad_ok = (kx >= w2x) && (kx < wh1_s1 + wx);
		side_c.flags.vert_ok = (kx >= w3x + 1'b1) && (kx < wh1_s1 + w2x - 1'b1);
		side_c.flags.res_ok  = (kx >= w3x + 2'd2) && (kx <= wh1_s1 + w2x - 1'b1);
		side_c.flags.last    = kx == wh1_s1 + w2x - 1'b1;
		side_c.flags.fs      = fs_s1;

		side_c.gx = $signed({1'b0, near_data}) - $signed({1'b0, tap2_q});
		side_c.gy = $signed({1'b0, pix_s1}) - $signed({1'b0, far_data});
		side_c.intensity = tap1_q;

		side_c.mag_wa  = AW'(kx - wx);
		side_c.mag_ra0 = AW'(kx - w2x);
		side_c.mag_ra1 = AW'(kx - w3x);
		side_c.gdel_wa = gmsm_pkg::GDEL_AW'(kx - wx);
		side_c.gdel_ra = gmsm_pkg::GDEL_AW'(kx - w2x - 1'b1);
		side_c.position = gmsm_pkg::POS_W'(kx - w2x - 1'b1);
	end

	// Stage 2 registers
	logic                 v_s2;
	gmsm_pkg::gmsm_side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_c;
		end
	end

	// Stage 2: squares
	logic signed [2*gmsm_pkg::GRAD_W-1:0] gx2, gy2;
	assign gx2 = side_s2.gx * side_s2.gx;
	assign gy2 = side_s2.gy * side_s2.gy;

	logic                       v_s3;
	gmsm_pkg::gmsm_side_t       side_s3;
	logic [gmsm_pkg::SQ_W-1:0]  gx2_s3, gy2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= side_s2;
			gx2_s3  <= gx2[gmsm_pkg::SQ_W-1:0];
			gy2_s3  <= gy2[gmsm_pkg::SQ_W-1:0];
		end
	end

	// Stage 3: sum of squares scaled into the radicand
	logic [gmsm_pkg::SQ_W-1:0] sum_c;
	assign sum_c = gx2_s3 + gy2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_valid <= 1'b0;
		end else if (adv) begin
			rad_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side <= side_s3;
			rad  <= gmsm_pkg::RAD_W'(sum_c) << (2 * gmsm_pkg::MAG_FRAC_BITS);
		end
	end

endmodule

`default_nettype wire

// File: hdl/gmsm_sqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Depends on gmsm_pkg; side data travels with each radicand.
`default_nettype none

module gmsm_sqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         adv,
	input  wire logic                         in_valid,
	input  wire logic [gmsm_pkg::RAD_W-1:0]   rad,
	input  wire gmsm_pkg::gmsm_side_t         side_in,
	output logic                              out_valid,
	output logic [gmsm_pkg::ROOT_W-1:0]       root,
	output gmsm_pkg::gmsm_side_t              side_out
);

	localparam int N  = gmsm_pkg::ROOT_W;
	localparam int RW = gmsm_pkg::RAD_W;
	localparam int MW = gmsm_pkg::REM_W;

	logic [N-1:0]         val_q;
	logic [RW-1:0]        rad_q  [N];
	logic [MW-1:0]        rem_q  [N];
	logic [N-1:0]         root_q [N];
	gmsm_pkg::gmsm_side_t side_q [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic                 pv;
		logic [RW-1:0]        pr;
		logic [MW-1:0]        pm, rem_sh, trial;
		logic [N-1:0]         pt;
		gmsm_pkg::gmsm_side_t ps;

		if (i == 0) begin : g_first
			assign pv = in_valid;
			assign pr = rad;
			assign pm = '0;
			assign pt = '0;
			assign ps = side_in;
		end else begin : g_next
			assign pv = val_q[i-1];
			assign pr = rad_q[i-1];
			assign pm = rem_q[i-1];
			assign pt = root_q[i-1];
			assign ps = side_q[i-1];
		end

		// bring down the next two radicand bits and try a one digit
		assign rem_sh = {pm[MW-3:0], pr[RW-1:RW-2]};
		assign trial  = MW'({pt, 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_q[i] <= 1'b0;
			end else if (adv) begin
				val_q[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rad_q[i]  <= pr << 2;
				side_q[i] <= ps;
				if (rem_sh >= trial) begin
					rem_q[i]  <= rem_sh - trial;
					root_q[i] <= {pt[N-2:0], 1'b1};
				end else begin
					rem_q[i]  <= rem_sh;
					root_q[i] <= {pt[N-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = val_q[N-1];
	assign root      = root_q[N-1];
	assign side_out  = side_q[N-1];

endmodule

`default_nettype wire

// File: hdl/gmsm_back.sv
// Back end: magnitude lines, vertical and horizontal 3-maximum, gradient delay line,
// mappable count and the output register. Depends on gmsm_pkg and gmsm_ram.
`default_nettype none

module gmsm_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                adv,
	input  wire logic                                in_valid,
	input  wire logic [gmsm_pkg::ROOT_W-1:0]         root,
	input  wire gmsm_pkg::gmsm_side_t                side,
	input  wire logic [gmsm_pkg::THR_W-1:0]          threshold,
	input  wire logic                                out_stall,
	output logic                                     res_pending,
	output logic                                     out_valid,
	output logic [gmsm_pkg::POS_W-1:0]               position,
	output logic signed [gmsm_pkg::GRAD_W-1:0]       grad_x_half,
	output logic signed [gmsm_pkg::GRAD_W-1:0]       grad_y_half,
	output logic [gmsm_pkg::PIX_W-1:0]               intensity,
	output logic [gmsm_pkg::MAG_W-1:0]               max_grad,
	output logic                                     mappable,
	output logic [gmsm_pkg::CNT_W-1:0]               mappable_count,
	output logic                                     frame_last
);

	localparam int AW = gmsm_pkg::PIX_AW;
	localparam int GW = gmsm_pkg::GRAD_W;

	// Magnitude from the root, zero outside the gradient rows
	logic [gmsm_pkg::ROOT_W-1:0] half_root;
	logic [gmsm_pkg::MAG_W-1:0]  mag_c;

	always_comb begin
		half_root = root >> 1;
		if (!side.flags.grad_ok) begin
			mag_c = '0;
		end else if (half_root > gmsm_pkg::ROOT_W'(gmsm_pkg::MAG_MAX)) begin
			mag_c = gmsm_pkg::MAG_MAX;
		end else begin
			mag_c = gmsm_pkg::MAG_W'(half_root);
		end
	end

	// Magnitude lines: write q, read p and p - width
	logic                        mag_we;
	logic [gmsm_pkg::MAG_W-1:0]  mag_p, mag_pm;

	assign mag_we = adv && in_valid && side.flags.mag_we;

	gmsm_ram #(.WIDTH(gmsm_pkg::MAG_W), .DEPTH(1 << AW)) u_mag_p (
		.clk(clk), .we(mag_we), .waddr(side.mag_wa), .wdata(mag_c),
		.re(adv), .raddr(side.mag_ra0), .rdata(mag_p)
	);

	gmsm_ram #(.WIDTH(gmsm_pkg::MAG_W), .DEPTH(1 << AW)) u_mag_pm (
		.clk(clk), .we(mag_we), .waddr(side.mag_wa), .wdata(mag_c),
		.re(adv), .raddr(side.mag_ra1), .rdata(mag_pm)
	);

	// Gradient delay line: gradients and intensity of q, read back at the result position
	logic                           gdel_we;
	logic [gmsm_pkg::GDEL_W-1:0]    gdel_wd, gdel_rd;

	assign gdel_we = adv && in_valid && side.flags.grad_ok;
	assign gdel_wd = {side.gx, side.gy, side.intensity};

	gmsm_ram #(.WIDTH(gmsm_pkg::GDEL_W), .DEPTH(1 << gmsm_pkg::GDEL_AW)) u_gdel (
		.clk(clk), .we(gdel_we), .waddr(side.gdel_wa), .wdata(gdel_wd),
		.re(adv), .raddr(side.gdel_ra), .rdata(gdel_rd)
	);

	// Stage 1 registers, aligned with the line read data
	logic                        v_s1;
	gmsm_pkg::gmsm_flags_t       flags_s1;
	logic [gmsm_pkg::MAG_W-1:0]  mag_s1;
	logic [gmsm_pkg::POS_W-1:0]  pos_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s1 <= side.flags;
			mag_s1   <= mag_c;
			pos_s1   <= side.position;
		end
	end

	// Vertical maximum over p - width, p, p + width
	logic [gmsm_pkg::MAG_W-1:0] vmax_c;
	assign vmax_c = flags_s1.vert_ok ? gmsm_pkg::max3(mag_pm, mag_p, mag_s1) : '0;

	logic                         v_s2;
	gmsm_pkg::gmsm_flags_t        flags_s2;
	logic [gmsm_pkg::MAG_W-1:0]   vmax_s2;
	logic [gmsm_pkg::POS_W-1:0]   pos_s2;
	logic [gmsm_pkg::GDEL_W-1:0]  gdel_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s2 <= flags_s1;
			vmax_s2  <= vmax_c;
			pos_s2   <= pos_s1;
			gdel_s2  <= gdel_rd;
		end
	end

	// Vertical maximum line: taps one and two items back
	logic [gmsm_pkg::MAG_W-1:0] vtap1_q, vtap2_q;

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			vtap1_q <= vmax_s2;
			vtap2_q <= vtap1_q;
		end
	end

	// Horizontal maximum, threshold and running count
	logic [gmsm_pkg::MAG_W-1:0] hmax_c;
	logic                       mappable_c;
	logic [gmsm_pkg::CNT_W-1:0] cnt_q, cnt_base, cnt_next;
	logic                       load_out;

	always_comb begin
		hmax_c     = gmsm_pkg::max3(vtap1_q, vmax_s2, vtap2_q);
		mappable_c = hmax_c >= threshold;
		cnt_base   = flags_s2.fs ? '0 : cnt_q;
		cnt_next   = cnt_base;
		if (flags_s2.res_ok && mappable_c && (cnt_base != gmsm_pkg::CNT_MAX)) begin
			cnt_next = cnt_base + 1'b1;
		end
	end

	assign res_pending = v_s2 && flags_s2.res_ok;
	assign load_out    = adv && res_pending;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (adv && v_s2) begin
			cnt_q <= cnt_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			position       <= pos_s2;
			grad_x_half    <= gdel_s2[gmsm_pkg::GDEL_W-1 -: GW];
			grad_y_half    <= gdel_s2[gmsm_pkg::GDEL_W-GW-1 -: GW];
			intensity      <= gdel_s2[gmsm_pkg::PIX_W-1:0];
			max_grad       <= hmax_c;
			mappable       <= mappable_c;
			mappable_count <= cnt_next;
			frame_last     <= flags_s2.last;
		end
	end

endmodule

`default_nettype wire

// File: hdl/gmsm_checker.sv
// Port-level checks on the result channel of gradient_max_smear_map_core, bound to it.
// Depends on gmsm_pkg for field widths.
`default_nettype none

module gmsm_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               out_valid,
	input wire logic                               out_stall,
	input wire logic [gmsm_pkg::POS_W-1:0]         position,
	input wire logic signed [gmsm_pkg::GRAD_W-1:0] grad_x_half,
	input wire logic signed [gmsm_pkg::GRAD_W-1:0] grad_y_half,
	input wire logic [gmsm_pkg::MAG_W-1:0]         max_grad,
	input wire logic                               mappable,
	input wire logic [gmsm_pkg::CNT_W-1:0]         mappable_count,
	input wire logic                               frame_last
);

	// a stalled transaction stays
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(position) && $stable(max_grad)
			&& $stable(mappable_count))
		else $error("result changed while stalled");

	// a mappable result is included in its own count
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mappable |-> mappable_count != '0)
		else $error("mappable result with zero count");

	// differences of 8-bit samples never reach the most negative code
	a_grad_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (grad_x_half != 9'sh100) && (grad_y_half != 9'sh100))
		else $error("gradient out of range");

	// the next frame needs at least two rows before its first result
	a_frame_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && frame_last |=> !out_valid)
		else $error("result right after the last of a frame");

endmodule

bind gradient_max_smear_map_core gmsm_checker u_gmsm_checker (.*);

`default_nettype wire
